/* hw/rtl/crc_pkg.sv */
// ----------------------------------------------------------------------------
// crc_pkg: shared types for the circle/rectangle contact test
// Side codes, per-axis band flags and the stage enables passed to each axis.
// ----------------------------------------------------------------------------
package crc_pkg;

	localparam int unsigned CoordW  = 16;
	localparam int unsigned RadiusW = 10;
	localparam int unsigned SizeW   = 12;
	// centre and edges after adding radius or size
	localparam int unsigned PosW    = CoordW + 2;
	// magnitude of the centre-to-closest-point distance on one axis
	localparam int unsigned DistW   = PosW;
	localparam int unsigned SqW     = 2 * DistW;
	localparam int unsigned RadSqW  = 2 * RadiusW;

	typedef enum logic [2:0] {
		SIDE_NONE   = 3'd0,
		SIDE_LEFT   = 3'd1,
		SIDE_RIGHT  = 3'd2,
		SIDE_TOP    = 3'd3,
		SIDE_BOTTOM = 3'd4
	} side_t;

	// closest point strictly inside the band below / above the centre
	typedef struct packed {
		logic below;
		logic above;
	} band_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

/* hw/rtl/circle_rect_collision_side.sv */
// ----------------------------------------------------------------------------
// circle_rect_collision_side: circle versus axis-aligned rectangle contact side
// Classifies the side of the rectangle that a circle touches, one request per
// clock while in_stall is low.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with the circle bounding-box corner,
//   radius, rectangle corner, width and height. A request is taken on a rising
//   edge where in_valid is high and in_stall is low.
//   Output channel: out_valid / out_stall with contact_side (none, left, right,
//   top, bottom), one result for every request, in order.
//   Pipeline: the accepting edge loads the input register; clamp, distance/bands
//   and squares are each registered in turn, and the compare lands in the output
//   register that drives out_valid.
//   Throughput: one request per cycle while nothing stalls; every stage takes one
//   request per clock whenever it moves. Each stage moves on when it is empty or
//   the next stage moves, so empty stages keep filling while a result waits under
//   out_stall; in_stall rises only once all five stages hold requests and the
//   output is stalled. Reset (arst_n low) empties the pipe: out_valid drops and
//   in-flight requests are discarded. The data registers are not reset.
// ----------------------------------------------------------------------------
module circle_rect_collision_side (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [crc_pkg::CoordW-1:0]  circle_x,
	input  logic signed [crc_pkg::CoordW-1:0]  circle_y,
	input  logic        [crc_pkg::RadiusW-1:0] radius,
	input  logic signed [crc_pkg::CoordW-1:0]  rect_x,
	input  logic signed [crc_pkg::CoordW-1:0]  rect_y,
	input  logic        [crc_pkg::SizeW-1:0]   rect_width,
	input  logic        [crc_pkg::SizeW-1:0]   rect_height,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic        [2:0]                  contact_side
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic en_s1, en_s4, en_out;
	crc_pkg::stage_en_t en_mid;

	logic signed [crc_pkg::CoordW-1:0]  circle_x_s1, circle_y_s1, rect_x_s1, rect_y_s1;
	logic        [crc_pkg::RadiusW-1:0] radius_s1, radius_s2, radius_s3;
	logic        [crc_pkg::SizeW-1:0]   rect_width_s1, rect_height_s1;

	logic [crc_pkg::DistW-1:0]  dist_x_s3, dist_y_s3;
	crc_pkg::band_t             band_x_s3, band_y_s3;

	logic [crc_pkg::SqW-1:0]    sq_x_s4, sq_y_s4;
	logic [crc_pkg::RadSqW-1:0] rad_sq_s4;
	crc_pkg::side_t             side_s4, side_q, side_cand;
	logic [crc_pkg::SqW:0]      dist_sq;

	// per-stage advance: a stage moves when empty or when the next one moves
	assign en_out    = !out_valid_q || !out_stall;
	assign en_s4     = !valid_s4 || en_out;
	assign en_mid.s3 = !valid_s3 || en_s4;
	assign en_mid.s2 = !valid_s2 || en_mid.s3;
	assign en_s1     = !valid_s1 || en_mid.s2;
	assign in_stall  = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)     valid_s1    <= in_valid;
			if (en_mid.s2) valid_s2    <= valid_s1;
			if (en_mid.s3) valid_s3    <= valid_s2;
			if (en_s4)     valid_s4    <= valid_s3;
			if (en_out)    out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			circle_x_s1    <= circle_x;
			circle_y_s1    <= circle_y;
			radius_s1      <= radius;
			rect_x_s1      <= rect_x;
			rect_y_s1      <= rect_y;
			rect_width_s1  <= rect_width;
			rect_height_s1 <= rect_height;
		end
		if (en_mid.s2) radius_s2 <= radius_s1;
		if (en_mid.s3) radius_s3 <= radius_s2;
	end

	crc_axis u_axis_x (
		.clk       (clk),
		.en        (en_mid),
		.corner_s1 (circle_x_s1),
		.radius_s1 (radius_s1),
		.edge_s1   (rect_x_s1),
		.size_s1   (rect_width_s1),
		.dist_s3   (dist_x_s3),
		.band_s3   (band_x_s3)
	);

	crc_axis u_axis_y (
		.clk       (clk),
		.en        (en_mid),
		.corner_s1 (circle_y_s1),
		.radius_s1 (radius_s1),
		.edge_s1   (rect_y_s1),
		.size_s1   (rect_height_s1),
		.dist_s3   (dist_y_s3),
		.band_s3   (band_y_s3)
	);

	// top/bottom wins over left/right
	always_comb begin
		if (band_y_s3.below) begin
			side_cand = crc_pkg::SIDE_TOP;
		end else if (band_y_s3.above) begin
			side_cand = crc_pkg::SIDE_BOTTOM;
		end else if (band_x_s3.below) begin
			side_cand = crc_pkg::SIDE_LEFT;
		end else if (band_x_s3.above) begin
			side_cand = crc_pkg::SIDE_RIGHT;
		end else begin
			side_cand = crc_pkg::SIDE_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			sq_x_s4   <= crc_pkg::SqW'(dist_x_s3) * crc_pkg::SqW'(dist_x_s3);
			sq_y_s4   <= crc_pkg::SqW'(dist_y_s3) * crc_pkg::SqW'(dist_y_s3);
			rad_sq_s4 <= crc_pkg::RadSqW'(radius_s3) * crc_pkg::RadSqW'(radius_s3);
			side_s4   <= side_cand;
		end
	end

	assign dist_sq = {1'b0, sq_x_s4} + {1'b0, sq_y_s4};

	always_ff @(posedge clk) begin
		if (en_out) begin
			if (dist_sq <= {{(crc_pkg::SqW+1-crc_pkg::RadSqW){1'b0}}, rad_sq_s4}) begin
				side_q <= side_s4;
			end else begin
				side_q <= crc_pkg::SIDE_NONE;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign contact_side = side_q;

`ifndef SYNTHESIS
	// the input side only backs up once every stage is full and the output stalls
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && out_valid_q && out_stall))
		else $error("in_stall raised with room in the pipe");

	// a zero radius never reports a side
	a_zero_radius_none: assert property (@(posedge clk) disable iff (!arst_n)
		(en_out && valid_s4 && rad_sq_s4 == '0) |=>
			(out_valid && contact_side == crc_pkg::SIDE_NONE))
		else $error("side reported for zero radius");

	// a drained output with nothing behind it goes idle
	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !valid_s4) |=> !out_valid_q)
		else $error("result repeated after it was taken");

	// a blocked squaring stage keeps its request
	a_s4_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !en_s4) |=> (valid_s4 && $stable(side_s4) && $stable(rad_sq_s4)))
		else $error("stage 4 request lost under stall");
`endif

endmodule

/* hw/rtl/crc_axis.sv */
// ----------------------------------------------------------------------------
// crc_axis: one axis of the contact test
// Centre, clamp to the rectangle span, distance magnitude and side band.
// ----------------------------------------------------------------------------
module crc_axis (
	input  logic                               clk,
	input  crc_pkg::stage_en_t                 en,
	input  logic signed [crc_pkg::CoordW-1:0]  corner_s1,
	input  logic        [crc_pkg::RadiusW-1:0] radius_s1,
	input  logic signed [crc_pkg::CoordW-1:0]  edge_s1,
	input  logic        [crc_pkg::SizeW-1:0]   size_s1,
	output logic        [crc_pkg::DistW-1:0]   dist_s3,
	output crc_pkg::band_t                     band_s3
);

	logic signed [crc_pkg::PosW-1:0]    centre;
	logic signed [crc_pkg::PosW-1:0]    far_edge;
	logic signed [crc_pkg::PosW-1:0]    near_edge;
	logic signed [crc_pkg::PosW-1:0]    clamped;

	logic signed [crc_pkg::PosW-1:0]    centre_s2;
	logic signed [crc_pkg::PosW-1:0]    point_s2;
	logic        [crc_pkg::RadiusW-1:0] radius_s2;

	logic signed [crc_pkg::PosW:0]      diff;
	logic signed [crc_pkg::PosW:0]      centre_ext;
	logic signed [crc_pkg::PosW:0]      point_ext;
	logic signed [crc_pkg::PosW:0]      rad_ext;
	logic        [crc_pkg::PosW:0]      diff_mag;
	crc_pkg::band_t                     band;

	// stage 2: centre and clamp
	always_comb begin
		centre    = crc_pkg::PosW'(corner_s1) +
			$signed({{(crc_pkg::PosW-crc_pkg::RadiusW){1'b0}}, radius_s1});
		near_edge = crc_pkg::PosW'(edge_s1);
		far_edge  = near_edge +
			$signed({{(crc_pkg::PosW-crc_pkg::SizeW){1'b0}}, size_s1});
		clamped   = centre;
		if (clamped > far_edge) begin
			clamped = far_edge;
		end
		if (clamped < near_edge) begin
			clamped = near_edge;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			centre_s2 <= centre;
			point_s2  <= clamped;
			radius_s2 <= radius_s1;
		end
	end

	// stage 3: distance magnitude and strict bands
	always_comb begin
		centre_ext = (crc_pkg::PosW+1)'(centre_s2);
		point_ext  = (crc_pkg::PosW+1)'(point_s2);
		rad_ext    = $signed({{(crc_pkg::PosW+1-crc_pkg::RadiusW){1'b0}}, radius_s2});
		diff       = point_ext - centre_ext;
		diff_mag   = diff[crc_pkg::PosW] ? $unsigned(-diff) : $unsigned(diff);
		band.below = (centre_ext < point_ext) && (point_ext < centre_ext + rad_ext);
		band.above = (centre_ext > point_ext) && (point_ext > centre_ext - rad_ext);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			dist_s3 <= diff_mag[crc_pkg::DistW-1:0];
			band_s3 <= band;
		end
	end

endmodule
